// ===== rtl/dsvs_pkg.sv =====
`default_nettype none
package dsvs_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_STEP = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_C2_LIGHT    = 3'd0;
	localparam logic [2:0] REG_C2_HEAVY    = 3'd1;
	localparam logic [2:0] REG_MASS_HEAVY  = 3'd2;
	localparam logic [2:0] REG_DAMPING     = 3'd3;
	localparam logic [2:0] REG_BOUNDARY    = 3'd4;
	localparam logic [2:0] REG_DRIVE_INDEX = 3'd5;
	localparam logic [2:0] REG_HEAVY_START = 3'd6;

	typedef struct packed {
		logic [15:0] c2_light;
		logic [15:0] c2_heavy;
		logic [15:0] mass_heavy;
		logic [15:0] damping;
		logic        open_ends;
		logic [8:0]  drive_index;
		logic [9:0]  heavy_start;
	} cfg_t;

	typedef struct packed {
		logic clr_we;
		logic strm_rd;
		logic pass_b;
		logic end_wr0;
		logic end_wr1;
		logic fetch;
		logic capt;
	} ctl_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
		if (x > 40'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (x < -40'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return x[31:0];
		end
	endfunction

	function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [62:0] b);
		logic [63:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[63]) begin
			return '1;
		end else begin
			return s[62:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/damped_string_verlet_step_top.sv =====
`default_nettype none
// Damped, driven string advanced one velocity-Verlet step at a time.
// The block stores POINTS samples of displacement and dt-scaled velocity,
// both signed Q8.24, in on-chip memories.
// A command word is accepted at a clock edge where start is high and busy is
// low. Load writes one point, read returns one point, and step advances the
// whole string and also returns the kinetic and potential energy sums.
// Every command answers with one result word: done is high for exactly one
// cycle, and the result ports hold the word until the next one. The receiver
// cannot stall the block, so done is never held back.
// A load or read passes through a fetch and a capture state before done. A
// step makes two streaming passes over the memories, each moving one point
// per cycle through the shared Laplacian, damping and update pipeline, with a
// drain and the boundary writes in between and the energy drain at the end.
// One command is processed at a time; busy stays high until done.
// After reset the block clears the displacement and velocity memories, one
// entry per cycle, with busy high.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// at any clock edge; they must only change while the block is idle.
module damped_string_verlet_step_top #(
	parameter int POINTS = 512
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	input  wire logic [1:0]         command,
	input  wire logic [8:0]         point_index,
	input  wire logic signed [31:0] disp_in,
	input  wire logic signed [31:0] vel_in,
	input  wire logic signed [31:0] force_now,
	input  wire logic signed [31:0] force_next,
	output logic signed [31:0]      disp_out,
	output logic signed [31:0]      vel_out,
	output logic [62:0]             kinetic_energy,
	output logic [62:0]             potential_energy,
	output logic                    status,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	import dsvs_pkg::*;

	cfg_t                      cfg_q;
	ctl_cmd_t                  cmd;
	dp_stat_t                  stat;
	logic [$clog2(POINTS)-1:0] addr;
	logic                      accept;

	assign accept = start && !busy;

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c2_light    <= 16'd8192;
			cfg_q.c2_heavy    <= 16'd8192;
			cfg_q.mass_heavy  <= 16'd256;
			cfg_q.damping     <= 16'd0;
			cfg_q.open_ends   <= 1'b0;
			cfg_q.drive_index <= 9'd0;
			cfg_q.heavy_start <= 10'd512;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_C2_LIGHT:    cfg_q.c2_light    <= cfg_data;
				REG_C2_HEAVY:    cfg_q.c2_heavy    <= cfg_data;
				REG_MASS_HEAVY:  cfg_q.mass_heavy  <= cfg_data;
				REG_DAMPING:     cfg_q.damping     <= cfg_data;
				REG_BOUNDARY:    cfg_q.open_ends   <= cfg_data[0];
				REG_DRIVE_INDEX: cfg_q.drive_index <= cfg_data[8:0];
				REG_HEAVY_START: cfg_q.heavy_start <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// The controller sequences the clearing sweep, the two step passes, the
	// boundary writes and the final read-back of the addressed point.
	dsvs_ctrl #(.POINTS(POINTS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(command),
		.stat(stat),
		.cmd(cmd),
		.addr(addr),
		.busy(busy),
		.done(done)
	);

	// The datapath holds the memories, the sliding window over the string,
	// the update pipeline and the energy accumulators.
	dsvs_dp #(.POINTS(POINTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(cmd),
		.addr(addr),
		.accept(accept),
		.command(command),
		.point_index(point_index),
		.disp_in(disp_in),
		.vel_in(vel_in),
		.force_now(force_now),
		.force_next(force_next),
		.stat(stat),
		.disp_out(disp_out),
		.vel_out(vel_out),
		.kinetic_energy(kinetic_energy),
		.potential_energy(potential_energy),
		.status(status)
	);

endmodule
`default_nettype wire

// ===== rtl/dsvs_ram.sv =====
`default_nettype none
module dsvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/dsvs_ctrl.sv =====
`default_nettype none
module dsvs_ctrl #(
	parameter int POINTS = 512
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [1:0]                command,
	input  dsvs_pkg::dp_stat_t             stat,
	output dsvs_pkg::ctl_cmd_t             cmd,
	output logic      [$clog2(POINTS)-1:0] addr,
	output logic                           busy,
	output logic                           done
);
	import dsvs_pkg::*;

	localparam int AW = $clog2(POINTS);

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b0000000001,
		S_IDLE    = 10'b0000000010,
		S_PASS_A  = 10'b0000000100,
		S_DRAIN_A = 10'b0000001000,
		S_END0    = 10'b0000010000,
		S_END1    = 10'b0000100000,
		S_PASS_B  = 10'b0001000000,
		S_DRAIN_B = 10'b0010000000,
		S_FETCH   = 10'b0100000000,
		S_CAPT    = 10'b1000000000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] ctr_q;
	logic          done_q;
	logic          last;

	assign last = (ctr_q == AW'(POINTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ctr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_CAPT);
			case (state_q)
				S_CLEAR: begin
					ctr_q <= last ? '0 : ctr_q + 1'b1;
					if (last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= (command == CMD_STEP) ? S_PASS_A : S_FETCH;
					end
				end
				S_PASS_A: begin
					ctr_q <= last ? '0 : ctr_q + 1'b1;
					if (last) begin
						state_q <= S_DRAIN_A;
					end
				end
				S_DRAIN_A: begin
					if (!stat.pipe_busy) begin
						state_q <= S_END0;
					end
				end
				S_END0: state_q <= S_END1;
				S_END1: state_q <= S_PASS_B;
				S_PASS_B: begin
					ctr_q <= last ? '0 : ctr_q + 1'b1;
					if (last) begin
						state_q <= S_DRAIN_B;
					end
				end
				S_DRAIN_B: begin
					if (!stat.pipe_busy) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_CAPT;
				S_CAPT:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.clr_we  = (state_q == S_CLEAR);
		cmd.strm_rd = (state_q == S_PASS_A) || (state_q == S_PASS_B);
		cmd.pass_b  = (state_q == S_PASS_B) || (state_q == S_DRAIN_B);
		cmd.end_wr0 = (state_q == S_END0);
		cmd.end_wr1 = (state_q == S_END1);
		cmd.fetch   = (state_q == S_FETCH);
		cmd.capt    = (state_q == S_CAPT);
	end

	assign addr = ctr_q;
	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

// ===== rtl/dsvs_dp.sv =====
`default_nettype none
module dsvs_dp #(
	parameter int POINTS = 512
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  dsvs_pkg::cfg_t                 cfg,
	input  dsvs_pkg::ctl_cmd_t             cmd,
	input  wire logic [$clog2(POINTS)-1:0] addr,
	input  wire logic                      accept,
	input  wire logic [1:0]                command,
	input  wire logic [8:0]                point_index,
	input  wire logic signed [31:0]        disp_in,
	input  wire logic signed [31:0]        vel_in,
	input  wire logic signed [31:0]        force_now,
	input  wire logic signed [31:0]        force_next,
	output dsvs_pkg::dp_stat_t             stat,
	output logic signed [31:0]             disp_out,
	output logic signed [31:0]             vel_out,
	output logic [62:0]                    kinetic_energy,
	output logic [62:0]                    potential_energy,
	output logic                           status
);
	import dsvs_pkg::*;

	localparam int AW = $clog2(POINTS);
	localparam int CW = (AW > 10) ? AW : 10;
	localparam int DW = (AW > 9) ? AW : 9;

	// Request latches
	logic [AW-1:0]      fidx_q;
	logic               ok_q, step_q;
	logic signed [31:0] fnow_q, fnext_q;
	logic               ok_in, load_we;

	// Memory ports
	logic               d_we, v_we, h_we;
	logic [AW-1:0]      d_wa, v_wa, rd_a;
	logic [31:0]        d_wd, v_wd, d_rd, v_rd, h_rd;

	// Stream window
	logic               rd_v_q;
	logic [AW-1:0]      rd_j_q;
	logic signed [31:0] up, vr, um_q, uc_q, wc_q;
	logic [AW-1:0]      cidx;

	// Update pipeline
	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [33:0] lap_s1;
	logic signed [31:0] u_s1, u_s2, u_s3, u_s4, w_s1, w_s2, w_s3, t_s4;
	logic [AW-1:0]      i_s1, i_s2, i_s3, i_s4;
	logic               hv_s1, hv_s2, hv_s3, hv_s4, dr_s1, dr_s2;
	logic signed [50:0] pc_s2;
	logic signed [48:0] pd_s2;
	logic signed [37:0] a_s3, a_c;
	logic signed [31:0] f_sel, t_c, u_new;
	logic signed [31:0] first_q, last_q;

	// Energy pipelines
	logic               kv1, kv2, pv1, pv2, pv3, pv4;
	logic signed [63:0] sq_k1;
	logic [15:0]        m_k1;
	logic [54:0]        ke_k2;
	logic signed [32:0] d_p1, nd;
	logic [31:0]        ad_p2;
	logic [63:0]        sq_p3;
	logic [55:0]        pe_p4;
	logic [62:0]        ek_q, ep_q;

	assign ok_in   = (32'(point_index) < 32'(POINTS));
	assign load_we = accept && (command == CMD_LOAD) && ok_in;

	dsvs_ram #(.WIDTH(32), .DEPTH(POINTS)) u_disp (
		.clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(rd_a), .rdata(d_rd));
	dsvs_ram #(.WIDTH(32), .DEPTH(POINTS)) u_vel (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(rd_a), .rdata(v_rd));
	dsvs_ram #(.WIDTH(32), .DEPTH(POINTS)) u_half (
		.clk(clk), .we(h_we), .waddr(i_s4), .wdata(t_s4), .raddr(addr), .rdata(h_rd));

	assign rd_a = cmd.fetch ? fidx_q : addr;

	always_comb begin
		d_we = 1'b1;
		d_wa = addr;
		d_wd = '0;
		if (cmd.clr_we) begin
			d_wd = '0;
		end else if (load_we) begin
			d_wa = AW'(point_index);
			d_wd = disp_in;
		end else if (cmd.end_wr0) begin
			d_wa = '0;
			d_wd = cfg.open_ends ? first_q : '0;
		end else if (cmd.end_wr1) begin
			d_wa = AW'(POINTS - 1);
			d_wd = cfg.open_ends ? last_q : '0;
		end else if (v_s4 && !cmd.pass_b) begin
			d_wa = i_s4;
			d_wd = u_new;
		end else begin
			d_we = 1'b0;
		end
	end

	always_comb begin
		v_we = 1'b1;
		v_wa = addr;
		v_wd = '0;
		if (cmd.clr_we) begin
			v_wd = '0;
		end else if (load_we) begin
			v_wa = AW'(point_index);
			v_wd = vel_in;
		end else if (v_s4 && cmd.pass_b) begin
			v_wa = i_s4;
			v_wd = t_s4;
		end else begin
			v_we = 1'b0;
		end
	end

	assign h_we = v_s4 && !cmd.pass_b;

	assign up    = d_rd;
	assign vr    = cmd.pass_b ? h_rd : v_rd;
	assign cidx  = rd_j_q - 1'b1;
	assign f_sel = cmd.pass_b ? fnext_q : fnow_q;
	assign a_c   = 38'(pc_s2 >>> 15) - 38'(pd_s2 >>> 15) + (dr_s2 ? 38'(f_sel) : 38'sd0);
	assign t_c   = sat32(40'(w_s3) + 40'(a_s3 >>> 1));
	assign u_new = sat32(40'(u_s4) + 40'(t_s4));
	assign nd    = -d_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			kv1    <= 1'b0;
			kv2    <= 1'b0;
			pv1    <= 1'b0;
			pv2    <= 1'b0;
			pv3    <= 1'b0;
			pv4    <= 1'b0;
		end else begin
			rd_v_q <= cmd.strm_rd;
			v_s1   <= rd_v_q && (rd_j_q >= AW'(2));
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			kv1    <= v_s4 && cmd.pass_b;
			kv2    <= kv1;
			pv1    <= rd_v_q && cmd.pass_b && (rd_j_q != '0);
			pv2    <= pv1;
			pv3    <= pv2;
			pv4    <= pv3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fidx_q  <= AW'(point_index);
			ok_q    <= ok_in;
			step_q  <= (command == CMD_STEP);
			fnow_q  <= force_now;
			fnext_q <= force_next;
		end
		rd_j_q <= addr;
		if (rd_v_q) begin
			um_q <= uc_q;
			uc_q <= up;
			wc_q <= vr;
		end

		lap_s1 <= 34'(up) - 34'(uc_q) - 34'(uc_q) + 34'(um_q);
		u_s1   <= uc_q;
		w_s1   <= wc_q;
		i_s1   <= cidx;
		hv_s1  <= (CW'(cidx) >= CW'(cfg.heavy_start));
		dr_s1  <= (DW'(cidx) == DW'(cfg.drive_index));

		pc_s2 <= $signed({1'b0, (hv_s1 ? cfg.c2_heavy : cfg.c2_light)}) * lap_s1;
		pd_s2 <= $signed({1'b0, cfg.damping}) * w_s1;
		u_s2  <= u_s1;
		w_s2  <= w_s1;
		i_s2  <= i_s1;
		hv_s2 <= hv_s1;
		dr_s2 <= dr_s1;

		a_s3  <= a_c;
		u_s3  <= u_s2;
		w_s3  <= w_s2;
		i_s3  <= i_s2;
		hv_s3 <= hv_s2;

		t_s4  <= t_c;
		u_s4  <= u_s3;
		i_s4  <= i_s3;
		hv_s4 <= hv_s3;

		// Open ends copy the freshly updated neighbors.
		if (v_s4 && !cmd.pass_b && (i_s4 == AW'(1))) begin
			first_q <= u_new;
		end
		if (v_s4 && !cmd.pass_b && (i_s4 == AW'(POINTS - 2))) begin
			last_q <= u_new;
		end

		// The square of the most negative velocity reaches bit 62.
		sq_k1 <= t_s4 * t_s4;
		m_k1  <= hv_s4 ? cfg.mass_heavy : 16'd256;
		ke_k2 <= sq_k1[62:24] * m_k1;

		d_p1  <= 33'(up) - 33'(uc_q);
		ad_p2 <= d_p1[32] ? nd[31:0] : d_p1[31:0];
		sq_p3 <= ad_p2 * ad_p2;
		pe_p4 <= sq_p3[63:24] * cfg.c2_light;

		if (accept && (command == CMD_STEP)) begin
			ek_q <= '0;
			ep_q <= '0;
		end else begin
			if (kv2) begin
				ek_q <= sat_add63(ek_q, 63'(ke_k2[54:9]));
			end
			if (pv4) begin
				ep_q <= sat_add63(ep_q, 63'(pe_p4[55:16]));
			end
		end

		if (cmd.capt) begin
			disp_out         <= ok_q ? d_rd : '0;
			vel_out          <= ok_q ? v_rd : '0;
			kinetic_energy   <= step_q ? ek_q : '0;
			potential_energy <= step_q ? ep_q : '0;
			status           <= !ok_q;
		end
	end

	assign stat.pipe_busy = rd_v_q || v_s1 || v_s2 || v_s3 || v_s4 || kv1 || kv2
		|| pv1 || pv2 || pv3 || pv4;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import dsvs_pkg::*;

	localparam int N = 512;
	localparam longint unsigned E_SAT = 64'h7FFF_FFFF_FFFF_FFFF;

	// One result word as the block should present it.
	typedef struct {
		logic signed [31:0] disp;
		logic signed [31:0] vel;
		logic [62:0]        ek;
		logic [62:0]        ep;
		logic               st;
	} string_word_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               done;
	logic [1:0]         command;
	logic [8:0]         point_index;
	logic signed [31:0] disp_in;
	logic signed [31:0] vel_in;
	logic signed [31:0] force_now;
	logic signed [31:0] force_next;
	logic signed [31:0] disp_out;
	logic signed [31:0] vel_out;
	logic [62:0]        kinetic_energy;
	logic [62:0]        potential_energy;
	logic               status;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	damped_string_verlet_step_top #(.POINTS(N)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.command(command), .point_index(point_index), .disp_in(disp_in),
		.vel_in(vel_in), .force_now(force_now), .force_next(force_next),
		.disp_out(disp_out), .vel_out(vel_out), .kinetic_energy(kinetic_energy),
		.potential_energy(potential_energy), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the string and of the register file.
	logic signed [31:0] shape[N];
	logic signed [31:0] speed[N];
	logic signed [31:0] half_speed[N];
	logic [15:0] c2_light, c2_heavy, mass_heavy, damping;
	logic        open_ends;
	logic [8:0]  drive_pt;
	logic [9:0]  heavy_from;

	string_word_t pending_words[$];
	int errors;
	int n_load, n_step, n_read;
	bit no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Timeout at %0t with %0d words outstanding.", $realtime, pending_words.size());
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic logic signed [31:0] clip32(longint x);
		if (x > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// Laplacian force plus damping plus drive for one interior point.
	function automatic longint point_accel(int i, longint v, longint f);
		longint lap, c2, a;
		lap = longint'(shape[i + 1]) - 2 * longint'(shape[i]) + longint'(shape[i - 1]);
		c2 = (i >= heavy_from) ? longint'(c2_heavy) : longint'(c2_light);
		a = ((c2 * lap) >>> 15) - ((longint'(damping) * v) >>> 15);
		if (i == drive_pt) begin
			a += f;
		end
		return a;
	endfunction

	function automatic void advance_string(longint f_now, longint f_next);
		longint acc[N];
		for (int i = 1; i <= N - 2; i++) acc[i] = point_accel(i, speed[i], f_now);
		for (int i = 1; i <= N - 2; i++)
			half_speed[i] = clip32(longint'(speed[i]) + (acc[i] >>> 1));
		for (int i = 1; i <= N - 2; i++)
			shape[i] = clip32(longint'(shape[i]) + longint'(half_speed[i]));
		// Fixed ends are pinned to zero, open ends follow their neighbor.
		shape[0] = open_ends ? shape[1] : 32'sd0;
		shape[N - 1] = open_ends ? shape[N - 2] : 32'sd0;
		for (int i = 1; i <= N - 2; i++) acc[i] = point_accel(i, half_speed[i], f_next);
		for (int i = 1; i <= N - 2; i++)
			speed[i] = clip32(longint'(half_speed[i]) + (acc[i] >>> 1));
	endfunction

	function automatic longint unsigned add_clip63(longint unsigned a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > E_SAT) ? E_SAT : s;
	endfunction

	function automatic string_word_t string_energies();
		string_word_t w;
		longint unsigned k, p, sq, m, ad;
		longint d;
		k = 0;
		p = 0;
		for (int i = 1; i <= N - 2; i++) begin
			d = speed[i];
			sq = longint'(d * d) >> 24;
			m = (i >= heavy_from) ? longint'(mass_heavy) : 256;
			k = add_clip63(k, (sq * m) >> 9);
		end
		for (int i = 1; i <= N - 1; i++) begin
			d = longint'(shape[i]) - longint'(shape[i - 1]);
			ad = (d < 0) ? longint'(-d) : d;
			sq = (ad * ad) >> 24;
			p = add_clip63(p, (sq * c2_light) >> 16);
		end
		w.ek = k[62:0];
		w.ep = p[62:0];
		return w;
	endfunction

	function automatic string_word_t apply_command(cmd_t c, logic [8:0] idx,
			logic signed [31:0] d, logic signed [31:0] v,
			logic signed [31:0] fn, logic signed [31:0] fx);
		string_word_t w;
		w.ek = '0;
		w.ep = '0;
		if (c == CMD_LOAD) begin
			shape[idx] = d;
			speed[idx] = v;
		end else if (c == CMD_STEP) begin
			advance_string(fn, fx);
			w = string_energies();
		end
		// The index port is 9 bits wide, so every index is within the string.
		w.disp = shape[idx];
		w.vel = speed[idx];
		w.st = 1'b0;
		return w;
	endfunction

	// Every done pulse must match the oldest pending prediction.
	always @(posedge clk) begin
		if (done) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word, disp_out %h", $realtime, disp_out);
				errors++;
			end else begin
				string_word_t w;
				w = pending_words.pop_front();
				if (disp_out !== w.disp) begin
					$display("%0t: disp_out expected %h actual %h", $realtime, w.disp, disp_out);
					errors++;
				end
				if (vel_out !== w.vel) begin
					$display("%0t: vel_out expected %h actual %h", $realtime, w.vel, vel_out);
					errors++;
				end
				if (kinetic_energy !== w.ek) begin
					$display("%0t: kinetic_energy expected %h actual %h", $realtime, w.ek,
						kinetic_energy);
					errors++;
				end
				if (potential_energy !== w.ep) begin
					$display("%0t: potential_energy expected %h actual %h", $realtime, w.ep,
						potential_energy);
					errors++;
				end
				if (status !== w.st) begin
					$display("%0t: status expected %b actual %b", $realtime, w.st, status);
					errors++;
				end
			end
		end
	end

	// Offers one command word and returns at the edge where it is taken.
	// Start is left high so that a back-to-back word needs no drop.
	task automatic send_word(cmd_t c, logic [8:0] idx, logic signed [31:0] d,
			logic signed [31:0] v, logic signed [31:0] fn, logic signed [31:0] fx);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= c;
		point_index <= idx;
		disp_in <= d;
		vel_in <= v;
		force_now <= fn;
		force_next <= fx;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_words.push_back(apply_command(c, idx, d, v, fn, fx));
		case (c)
			CMD_LOAD: n_load++;
			CMD_STEP: n_step++;
			default:  n_read++;
		endcase
	endtask

	// Drops start and waits until every word is back and the block has settled.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Only called while the block is idle.
	task automatic write_reg(logic [2:0] r, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_C2_LIGHT:    c2_light = val;
			REG_C2_HEAVY:    c2_heavy = val;
			REG_MASS_HEAVY:  mass_heavy = val;
			REG_DAMPING:     damping = val;
			REG_BOUNDARY:    open_ends = val[0];
			REG_DRIVE_INDEX: drive_pt = val[8:0];
			REG_HEAVY_START: heavy_from = val[9:0];
			default: ;
		endcase
	endtask

	task automatic set_all(logic [15:0] cl, logic [15:0] ch, logic [15:0] m,
			logic [15:0] dmp, logic ob, logic [8:0] dr, logic [9:0] hs);
		write_reg(REG_C2_LIGHT, cl);
		write_reg(REG_C2_HEAVY, ch);
		write_reg(REG_MASS_HEAVY, m);
		write_reg(REG_DAMPING, dmp);
		write_reg(REG_BOUNDARY, {15'd0, ob});
		write_reg(REG_DRIVE_INDEX, {7'd0, dr});
		write_reg(REG_HEAVY_START, {6'd0, hs});
	endtask

	function automatic logic signed [31:0] rand_value();
		// Mostly modest amplitudes so the string evolves, sometimes full range.
		case ($urandom_range(3))
			0:       return $urandom;
			1:       return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
			default: return $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
		endcase
	endfunction

	// Extremes of the fields, every command, and the named corner cases.
	task automatic test_directed();
		send_word(CMD_LOAD, 9'd0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0);
		send_word(CMD_LOAD, 9'd511, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
		send_word(CMD_READ, 9'd0, 0, 0, 0, 0);
		send_word(CMD_READ, 9'd511, 0, 0, 0, 0);
		send_word(CMD_NONE, 9'd511, 32'sh1234, 32'sh5678, 0, 0);
		send_word(CMD_LOAD, 9'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0);
		send_word(CMD_LOAD, 9'd2, 32'sh80000000, 32'sh80000000, 0, 0);
		send_word(CMD_LOAD, 9'd255, 32'sh0100_0000, 32'sh0000_1000, 0, 0);
		// Reset settings: fixed ends, no drive, heavy half off.
		send_word(CMD_STEP, 9'd1, 0, 0, 32'sh7FFFFFFF, 32'sh80000000);
		send_word(CMD_READ, 9'd0, 0, 0, 0, 0);
		send_word(CMD_READ, 9'd511, 0, 0, 0, 0);
		drain();
		// Largest coefficients, open ends, drive at the last interior point.
		set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 9'd510, 10'd256);
		write_reg(3'd7, 16'hFFFF);
		send_word(CMD_STEP, 9'd510, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_word(CMD_STEP, 9'd0, 0, 0, 32'sh80000000, 32'sh80000000);
		send_word(CMD_READ, 9'd511, 0, 0, 0, 0);
		drain();
		// Drive at the end point drives nothing; all points heavy.
		set_all(16'd0, 16'h4000, 16'd256, 16'd0, 1'b0, 9'd511, 10'd0);
		send_word(CMD_STEP, 9'd256, 0, 0, 32'sh0100_0000, 32'sh0100_0000);
		send_word(CMD_LOAD, 9'd100, 32'sh0040_0000, 32'sh0010_0000, 0, 0);
		drain();
		set_all(16'h2000, 16'h0800, 16'h0400, 16'h0100, 1'b0, 9'd100, 10'd1023);
		send_word(CMD_STEP, 9'd100, 0, 0, 32'sh0080_0000, 32'shFF80_0000);
		send_word(CMD_READ, 9'd99, 0, 0, 0, 0);
		drain();
	endtask

	// One phase of random words under the current register settings.
	task automatic test_random_phase(int count);
		int pick;
		no_gaps = ($urandom_range(3) == 0);
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 14) begin
				send_word(CMD_STEP, 9'($urandom), $urandom, $urandom,
					rand_value(), rand_value());
			end else if (pick < 60) begin
				send_word(CMD_LOAD, 9'($urandom), rand_value(), rand_value(),
					$urandom, $urandom);
			end else if (pick < 95) begin
				send_word(CMD_READ, 9'($urandom), $urandom, $urandom, $urandom, $urandom);
			end else begin
				send_word(CMD_NONE, 9'($urandom), $urandom, $urandom, $urandom, $urandom);
			end
			if (k % 30 == 29) begin
				no_gaps = ($urandom_range(3) == 0);
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_READ;
		point_index = '0;
		disp_in = '0;
		vel_in = '0;
		force_now = '0;
		force_next = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		n_load = 0;
		n_step = 0;
		n_read = 0;
		no_gaps = 1'b0;
		c2_light = 16'd8192;
		c2_heavy = 16'd8192;
		mass_heavy = 16'd256;
		damping = 16'd0;
		open_ends = 1'b0;
		drive_pt = 9'd0;
		heavy_from = 10'd512;
		foreach (shape[i]) begin
			shape[i] = '0;
			speed[i] = '0;
			half_speed[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// Typical physical settings, then random ones, then the extremes.
		set_all(16'h2000, 16'h1000, 16'h0200, 16'h0040, 1'b0, 9'd200, 10'd300);
		test_random_phase(90);
		set_all(16'($urandom), 16'($urandom), 16'($urandom_range(16'hFFFF, 256)),
			16'($urandom), 1'($urandom), 9'($urandom), 10'($urandom_range(512)));
		test_random_phase(90);
		set_all(16'h7FFF, 16'h0001, 16'd256, 16'd0, 1'b1, 9'd0, 10'd512);
		test_random_phase(85);
		set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 9'd1, 10'd1);
		test_random_phase(85);

		repeat (20) @(posedge clk);
		$display("Covered %0d load, %0d step and %0d read or idle command words", n_load,
			n_step, n_read);
		$display("under eight register settings with fixed and open ends.");
		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
